FILE: hw/rtl/ncpc_pkg.sv
// Shared types and constants of the nearest centroid patch coder.
`timescale 1ns / 1ps

package ncpc_pkg;

	// Sizes of the center table and the patch
	localparam int CLUSTERS       = 16;
	localparam int PATCH_ELEMENTS = 16;

	// Field widths fixed by the stream format
	localparam int SEL_W    = 4;
	localparam int SMP_W    = 16;
	localparam int CODE_W   = 16;
	localparam int CODEO_W  = 17;
	localparam int WIN_W    = 4;
	localparam int DIST_W   = 36;
	localparam int MODE_W   = 2;
	localparam int IN_DW    = 88;
	localparam int OUT_DW   = 112;

	// Derived widths
	localparam int IDX_W    = $clog2(CLUSTERS);
	localparam int POS_W    = $clog2(PATCH_ELEMENTS);
	localparam int PCNT_W   = $clog2(PATCH_ELEMENTS + 1);
	localparam int SQ_W     = 2 * SMP_W;
	localparam int SUM_W    = SQ_W + $clog2(PATCH_ELEMENTS + 1);
	localparam int DEPTH    = 2 * CLUSTERS + 1;
	localparam int FLIGHT_W = $clog2(DEPTH + 1);

	localparam logic signed [CODE_W-1:0] BIAS_RESET = 16'sd100;

	typedef enum logic [MODE_W-1:0] {
		MODE_CENTER = 2'd0,
		MODE_CODES  = 2'd1,
		MODE_PIXEL  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Token that travels along the row of cells
	typedef struct packed {
		logic signed [SMP_W-1:0] pixel;
		logic [POS_W-1:0]        pos;
		logic                    add;
		logic                    last;
		logic [SUM_W-1:0]        best_sum;
		logic [IDX_W-1:0]        best_idx;
	} tok_t;

	// Center element write broadcast to all cells
	typedef struct packed {
		logic                    we;
		logic [IDX_W-1:0]        cluster;
		logic [POS_W-1:0]        element;
		logic signed [SMP_W-1:0] value;
	} ld_t;

endpackage

FILE: hw/rtl/ncpc_cell.sv
// One cluster cell: center row, squared difference, running sum, min compare.
`timescale 1ns / 1ps

module ncpc_cell import ncpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_id,
	input  ld_t              ld,
	input  logic             tok_in_valid,
	input  tok_t             tok_in,
	output logic             tok_out_valid,
	output tok_t             tok_out
);

	logic signed [SMP_W-1:0] center_q [PATCH_ELEMENTS];
	logic signed [SMP_W-1:0] center_rd;
	logic signed [SMP_W:0]   diff;
	logic signed [2*SMP_W+1:0] prod;
	logic                    v_s1;
	tok_t                    tok_s1;
	logic [SQ_W-1:0]         prod_s1;
	logic [SUM_W-1:0]        sum_q;
	logic [SUM_W-1:0]        new_sum;
	logic                    take;
	tok_t                    tok_nxt;
	logic                    out_valid_q;
	tok_t                    tok_out_q;

	// Store center elements addressed to this cluster
	always_ff @(posedge clk) begin
		if (ld.we && (int'(ld.cluster) == int'(cell_id))) begin
			center_q[ld.element] <= ld.value;
		end
	end

	// Square the difference between center element and pixel
	always_comb begin
		center_rd = center_q[tok_in.pos];
		diff      = {center_rd[SMP_W-1], center_rd} - {tok_in.pixel[SMP_W-1], tok_in.pixel};
		prod      = diff * diff;
	end

	// Accumulate and keep the first strictly smallest sum
	always_comb begin
		new_sum = sum_q + (tok_s1.add ? SUM_W'(prod_s1) : '0);
		take    = (cell_id == '0) || (new_sum < tok_s1.best_sum);
		tok_nxt = tok_s1;
		if (take) begin
			tok_nxt.best_sum = new_sum;
			tok_nxt.best_idx = cell_id;
		end
	end

	// Hold the square until the accumulate step
	always_ff @(posedge clk) begin
		tok_s1  <= tok_in;
		prod_s1 <= prod[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			v_s1        <= tok_in_valid;
			out_valid_q <= v_s1;
			if (v_s1) begin
				// Drop the sum once the patch closes
				sum_q <= tok_s1.last ? '0 : new_sum;
			end
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk) begin
		tok_out_q <= tok_nxt;
	end

	assign tok_out_valid = out_valid_q;
	assign tok_out       = tok_out_q;

endmodule

FILE: hw/rtl/nearest_centroid_patch_coder.sv
// Top level of the nearest centroid patch coder: input decode, cell row, result stage.
`timescale 1ns / 1ps

// Loads (center elements, cluster codes) are held off until no pixel is left in
// the cell row. Patch pixels enter one per cycle and travel the row of CLUSTERS
// cells, each registering the token after its square and after its compare, and
// the result is registered from the patch-end token as it leaves the last cell. Only one
// patch end may be in the row at a time, and a patch-end pixel also waits while
// the previous result has not been taken; pixels without the flag never wait.

module nearest_centroid_patch_coder import ncpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CODE_W-1:0] cfg_wdata,  // code_bias
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// cluster_sel[3:0], element_sel[7:4], sample[23:8],
	// code_a_in[39:24], code_b_in[55:40], code_c_in[71:56], code_d_in[87:72]
	input  logic [IN_DW-1:0]  s_axis_tdata,
	input  logic [MODE_W-1:0] s_axis_tuser,   // mode[1:0]
	input  logic              s_axis_tlast,   // patch_end
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// winner[3:0], best_distance[39:4], code_a_out[56:40], code_b_out[73:57],
	// code_c_out[90:74], code_d_out[107:91]
	output logic [OUT_DW-1:0] m_axis_tdata
);

	mode_t                   in_mode;
	logic [SEL_W-1:0]        in_csel;
	logic [SEL_W-1:0]        in_esel;
	logic signed [SMP_W-1:0] in_sample;
	logic [4*CODE_W-1:0]     in_codes;
	logic                    in_acc;
	logic                    pix_acc;

	logic signed [CODE_W-1:0] bias_q;
	logic [PCNT_W-1:0]       pos_q;
	logic [FLIGHT_W-1:0]     flight_q;
	logic                    end_busy_q;
	ld_t                     ld_q;
	logic [4*CODE_W-1:0]     code_q [CLUSTERS];

	logic                    tok_v_s0;
	tok_t                    tok_s0;
	logic                    chain_v [CLUSTERS+1];
	tok_t                    chain_t [CLUSTERS+1];
	logic                    exit_v;
	tok_t                    exit_t;

	logic [4*CODE_W-1:0]     win_codes;
	logic [DIST_W-1:0]       dist_sat;
	logic [4*CODEO_W-1:0]    codes_out;
	logic                    m_valid_q;
	logic [OUT_DW-1:0]       m_data_q;

	// Unpack the request
	always_comb begin
		in_mode   = mode_t'(s_axis_tuser);
		in_csel   = s_axis_tdata[3:0];
		in_esel   = s_axis_tdata[7:4];
		in_sample = s_axis_tdata[23:8];
		in_codes  = s_axis_tdata[87:24];
	end

	// Take pixels freely, a patch end with no end or result pending, loads on empty row
	always_comb begin
		case (in_mode)
			MODE_PIXEL:  s_axis_tready = !s_axis_tlast || (!end_busy_q && !m_valid_q);
			MODE_CENTER: s_axis_tready = (flight_q == '0);
			MODE_CODES:  s_axis_tready = (flight_q == '0);
			default:     s_axis_tready = 1'b1;
		endcase
	end

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign pix_acc = in_acc && (in_mode == MODE_PIXEL);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= BIAS_RESET;
		end else if (cfg_we) begin
			bias_q <= cfg_wdata;
		end
	end

	// Pixel position, tokens in flight, pending patch end, center load request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			flight_q   <= '0;
			end_busy_q <= 1'b0;
			tok_v_s0   <= 1'b0;
			ld_q       <= '0;
		end else begin
			tok_v_s0 <= pix_acc;
			ld_q     <= '{
				we:      in_acc && (in_mode == MODE_CENTER)
					&& (int'(in_csel) < CLUSTERS) && (int'(in_esel) < PATCH_ELEMENTS),
				cluster: IDX_W'(in_csel),
				element: POS_W'(in_esel),
				value:   in_sample
			};
			if (pix_acc) begin
				if (s_axis_tlast) begin
					pos_q <= '0;
				end else if (int'(pos_q) < PATCH_ELEMENTS) begin
					pos_q <= pos_q + PCNT_W'(1);
				end
			end
			case ({pix_acc, exit_v})
				2'b10:   flight_q <= flight_q + FLIGHT_W'(1);
				2'b01:   flight_q <= flight_q - FLIGHT_W'(1);
				default: flight_q <= flight_q;
			endcase
			if (pix_acc && s_axis_tlast) begin
				end_busy_q <= 1'b1;
			end else if (exit_v && exit_t.last) begin
				end_busy_q <= 1'b0;
			end
		end
	end

	// Build the token
	always_ff @(posedge clk) begin
		tok_s0 <= '{
			pixel:    in_sample,
			pos:      POS_W'(pos_q),
			add:      (int'(pos_q) < PATCH_ELEMENTS),
			last:     s_axis_tlast,
			best_sum: '0,
			best_idx: '0
		};
	end

	// Cluster code table
	always_ff @(posedge clk) begin
		if (in_acc && (in_mode == MODE_CODES) && (int'(in_csel) < CLUSTERS)) begin
			code_q[IDX_W'(in_csel)] <= in_codes;
		end
	end

	// Row of cluster cells
	assign chain_v[0] = tok_v_s0;
	assign chain_t[0] = tok_s0;

	for (genvar c = 0; c < CLUSTERS; c++) begin : g_cell
		ncpc_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cell_id       (IDX_W'(c)),
			.ld            (ld_q),
			.tok_in_valid  (chain_v[c]),
			.tok_in        (chain_t[c]),
			.tok_out_valid (chain_v[c+1]),
			.tok_out       (chain_t[c+1])
		);
	end

	assign exit_v = chain_v[CLUSTERS];
	assign exit_t = chain_t[CLUSTERS];

	// Saturate the distance and add the bias to the winner's codes
	always_comb begin
		win_codes = code_q[exit_t.best_idx];
		dist_sat  = (|exit_t.best_sum[SUM_W-1:DIST_W]) ? '1 : exit_t.best_sum[DIST_W-1:0];
		for (int k = 0; k < 4; k++) begin
			codes_out[k*CODEO_W +: CODEO_W] =
				{win_codes[k*CODE_W + CODE_W-1], win_codes[k*CODE_W +: CODE_W]}
				+ {bias_q[CODE_W-1], bias_q};
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (exit_v && exit_t.last) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exit_v && exit_t.last) begin
			m_data_q <= {4'b0000, codes_out, dist_sat, WIN_W'(exit_t.best_idx)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// A closing token always finds the result slot free
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		exit_v && exit_t.last |-> !m_valid_q)
		else $error("patch result would overwrite a pending result");

	// The row never holds more tokens than it has stages
	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(flight_q) <= DEPTH)
		else $error("token count exceeds row depth");

	// A pending patch end implies a token in the row
	a_end_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		end_busy_q |-> flight_q != '0)
		else $error("patch end pending with empty row");

	// Clearing the pending patch end always leaves a result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(end_busy_q) |-> m_valid_q)
		else $error("patch end retired without a result");

endmodule

FILE: tb/tb_nearest_centroid_patch_coder.sv
// Self-checking testbench for the nearest centroid patch coder stream block.
`timescale 1ns / 1ps

module tb_nearest_centroid_patch_coder;
	import ncpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 2 * CLUSTERS + 8;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_ITEMS   = 200;
	localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 1;

	// One input request as it travels on the slave stream
	typedef struct packed {
		mode_t                    mode;
		logic [SEL_W-1:0]         cluster;
		logic [SEL_W-1:0]         element;
		logic signed [SMP_W-1:0]  sample;
		logic signed [CODE_W-1:0] code_a;
		logic signed [CODE_W-1:0] code_b;
		logic signed [CODE_W-1:0] code_c;
		logic signed [CODE_W-1:0] code_d;
		logic                     patch_end;
	} patch_req_t;

	// One coded patch as expected on the master stream
	typedef struct packed {
		logic [WIN_W-1:0]   winner;
		logic [DIST_W-1:0]  distance;
		logic [CODEO_W-1:0] code_a;
		logic [CODEO_W-1:0] code_b;
		logic [CODEO_W-1:0] code_c;
		logic [CODEO_W-1:0] code_d;
	} code_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CODE_W-1:0] cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata;
	logic [MODE_W-1:0] s_axis_tuser;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_DW-1:0] m_axis_tdata;

	nearest_centroid_patch_coder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Predictor state
	logic signed [SMP_W-1:0]  center_tab [CLUSTERS][PATCH_ELEMENTS];
	logic signed [CODE_W-1:0] code_tab [CLUSTERS][4];
	longint unsigned          dist_sums [CLUSTERS];
	int                       pixel_count;
	logic signed [CODE_W-1:0] bias_q;
	code_result_t             expected_codes [$];

	int  errors;
	int  idle_cycles;
	int  rx_stall;
	int  rx_hold_left;
	bit  rx_hold_req;
	bit  rx_steady;
	bit  tx_steady;
	code_result_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CODEO_W-1:0] add_bias(input logic signed [CODE_W-1:0] code);
		int v;
		v = code + bias_q;
		return v[CODEO_W-1:0];
	endfunction

	// Advance the predictor by one accepted request
	task automatic predict_patch_code(input patch_req_t r);
		longint diff;
		int c;
		int best;
		code_result_t res;
		case (r.mode)
			MODE_CENTER: begin
				center_tab[r.cluster][r.element] = r.sample;
			end
			MODE_CODES: begin
				code_tab[r.cluster][0] = r.code_a;
				code_tab[r.cluster][1] = r.code_b;
				code_tab[r.cluster][2] = r.code_c;
				code_tab[r.cluster][3] = r.code_d;
			end
			MODE_PIXEL: begin
				// pixels past the patch size add nothing
				if (pixel_count < PATCH_ELEMENTS) begin
					for (c = 0; c < CLUSTERS; c++) begin
						diff = longint'(center_tab[c][pixel_count]) - longint'(r.sample);
						dist_sums[c] += longint'(diff * diff);
					end
					pixel_count++;
				end
				if (r.patch_end) begin
					// lowest index wins a tie
					best = 0;
					for (c = 1; c < CLUSTERS; c++)
						if (dist_sums[c] < dist_sums[best])
							best = c;
					res.winner   = best[WIN_W-1:0];
					res.distance = (dist_sums[best] > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
						: dist_sums[best][DIST_W-1:0];
					res.code_a = add_bias(code_tab[best][0]);
					res.code_b = add_bias(code_tab[best][1]);
					res.code_c = add_bias(code_tab[best][2]);
					res.code_d = add_bias(code_tab[best][3]);
					expected_codes.push_back(res);
					for (c = 0; c < CLUSTERS; c++)
						dist_sums[c] = 0;
					pixel_count = 0;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic signed [SMP_W-1:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// Build a request; unused fields carry random values
	function automatic patch_req_t make_req(input mode_t mode, input int cluster,
			input int element, input logic signed [SMP_W-1:0] sample, input bit patch_end);
		patch_req_t r;
		r.mode      = mode;
		r.cluster   = cluster[SEL_W-1:0];
		r.element   = element[SEL_W-1:0];
		r.sample    = sample;
		r.code_a    = rand_sample();
		r.code_b    = rand_sample();
		r.code_c    = rand_sample();
		r.code_d    = rand_sample();
		r.patch_end = patch_end;
		return r;
	endfunction

	function automatic patch_req_t rand_req();
		return make_req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
			$urandom_range(0, 15), rand_sample(), $urandom_range(0, 1));
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_req(input patch_req_t r);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.code_d, r.code_c, r.code_b, r.code_a,
			r.sample, r.element, r.cluster};
		s_axis_tuser  <= r.mode;
		s_axis_tlast  <= r.patch_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_patch_code(r);
	endtask

	task automatic send_patch(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_req(make_req(MODE_PIXEL, $urandom_range(0, 15), $urandom_range(0, 15),
				rand_sample(), i == len - 1));
	endtask

	function automatic int rand_patch_len();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return PATCH_ELEMENTS;
		else if (pick < 8)
			return $urandom_range(1, PATCH_ELEMENTS - 1);
		else
			return $urandom_range(PATCH_ELEMENTS + 1, PATCH_ELEMENTS + 4);
	endfunction

	// Stop offering, wait for every result, then let the cell row empty
	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bias(input logic signed [CODE_W-1:0] value);
		wait_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		bias_q = value;
	endtask

	// Make cluster 0 win with zero distance so its extreme codes meet the bias
	task automatic probe_bias();
		patch_req_t r;
		r = make_req(MODE_CODES, 0, $urandom_range(0, 15), rand_sample(), $urandom_range(0, 1));
		r.code_a = 16'sh7fff;
		r.code_b = 16'sh8000;
		r.code_c = 16'sh0000;
		r.code_d = 16'shffff;
		send_req(r);
		send_req(make_req(MODE_CENTER, 0, 0, 16'sh7fff, $urandom_range(0, 1)));
		send_req(make_req(MODE_PIXEL, $urandom_range(0, 15), $urandom_range(0, 15),
			16'sh7fff, 1'b1));
	endtask

	// Fill every center element and code so no patch reads an unwritten entry
	task automatic test_table_load();
		patch_req_t r;
		int c;
		int e;
		for (c = 0; c < CLUSTERS; c++) begin
			for (e = 0; e < PATCH_ELEMENTS; e++)
				send_req(make_req(MODE_CENTER, c, e, 16'sh8000, $urandom_range(0, 1)));
			r = make_req(MODE_CODES, c, $urandom_range(0, 15), rand_sample(),
				$urandom_range(0, 1));
			r.code_a = SMP_W'($urandom);
			r.code_b = SMP_W'($urandom);
			send_req(r);
		end
	endtask

	task automatic test_directed();
		patch_req_t r;
		int i;
		// all clusters tie at the largest distance
		for (i = 0; i < PATCH_ELEMENTS; i++)
			send_req(make_req(MODE_PIXEL, $urandom_range(0, 15), $urandom_range(0, 15),
				16'sh7fff, i == PATCH_ELEMENTS - 1));
		// mode three is dropped even with the end flag
		r = rand_req();
		r.mode      = MODE_NONE;
		r.patch_end = 1'b1;
		send_req(r);
		// loads ignore the end flag
		r = make_req(MODE_CODES, 3, 9, 16'sh8000, 1'b1);
		r.code_a = 16'sh7fff;
		r.code_b = 16'sh8000;
		r.code_c = 16'sh0000;
		r.code_d = 16'shffff;
		send_req(r);
		send_req(make_req(MODE_CENTER, 3, 0, 16'sh7fff, 1'b1));
		// one-pixel patch, cluster 3 at zero distance
		send_req(make_req(MODE_PIXEL, 0, 0, 16'sh7fff, 1'b1));
	endtask

	task automatic test_bias_settings();
		logic signed [CODE_W-1:0] values [4];
		int i;
		values[0] = 16'sh7fff;
		values[1] = 16'sh8000;
		values[2] = 16'sh0000;
		values[3] = CODE_W'($urandom);
		for (i = 0; i < 4; i++) begin
			set_bias(values[i]);
			probe_bias();
			send_patch(PATCH_ELEMENTS);
		end
	endtask

	// Hold the result side off while short patches pile up at the input
	task automatic test_backpressure();
		int i;
		rx_hold_req = 1'b1;
		for (i = 0; i < 6; i++)
			send_patch($urandom_range(1, 3));
		send_req(make_req(MODE_CENTER, $urandom_range(0, 15), $urandom_range(0, 15),
			rand_sample(), 1'b0));
		send_patch(PATCH_ELEMENTS);
		wait_drain();
	endtask

	task automatic test_random();
		patch_req_t r;
		int count;
		int next_pause;
		int kind;
		int len;
		count = 0;
		next_pause = 150;
		while (count < RANDOM_ITEMS) begin
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				len = rand_patch_len();
				send_patch(len);
				count += len;
			end else if (kind < 7) begin
				send_req(make_req(MODE_CENTER, $urandom_range(0, 15), $urandom_range(0, 15),
					rand_sample(), $urandom_range(0, 1)));
				count++;
			end else if (kind < 8) begin
				send_req(make_req(MODE_CODES, $urandom_range(0, 15), $urandom_range(0, 15),
					rand_sample(), $urandom_range(0, 1)));
				count++;
			end else begin
				r = rand_req();
				send_req(r);
				if (r.mode != MODE_NONE)
					count++;
			end
			// pause the sender now and then and move to a new bias
			if (count >= next_pause) begin
				next_pause += 150;
				set_bias(CODE_W'($urandom));
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Drive the result ready with random stalls and the long hold
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = LONG_HOLD;
		end
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic void compare_field(input string name, input logic [DIST_W-1:0] exp_v,
			input logic [DIST_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Check each result against the oldest expected code
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_codes.size() == 0) begin
				$display("%0t: result with no request waiting: expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = expected_codes.pop_front();
				compare_field("winner", want.winner, m_axis_tdata[3:0]);
				compare_field("best_distance", want.distance, m_axis_tdata[39:4]);
				compare_field("code_a_out", want.code_a, m_axis_tdata[56:40]);
				compare_field("code_b_out", want.code_b, m_axis_tdata[73:57]);
				compare_field("code_c_out", want.code_c, m_axis_tdata[90:74]);
				compare_field("code_d_out", want.code_d, m_axis_tdata[107:91]);
			end
			rx_stall = rx_steady ? 0 : $urandom_range(0, 15);
		end
	end

	// End the run when neither side moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_nearest_centroid_patch_coder: FAIL");
			$finish;
		end
	end

	initial begin
		int c;
		int e;
		errors        = 0;
		idle_cycles   = 0;
		rx_stall      = 0;
		rx_hold_left  = 0;
		rx_hold_req   = 1'b0;
		rx_steady     = 1'b0;
		tx_steady     = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		// predictor starts from the reset state
		bias_q      = BIAS_RESET;
		pixel_count = 0;
		for (c = 0; c < CLUSTERS; c++) begin
			dist_sums[c] = 0;
			for (e = 0; e < PATCH_ELEMENTS; e++)
				center_tab[c][e] = '0;
			for (e = 0; e < 4; e++)
				code_tab[c][e] = '0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_table_load();
		test_directed();
		test_bias_settings();
		test_backpressure();
		test_random();
		wait_drain();

		if (errors == 0 && expected_codes.size() == 0)
			$display("tb_nearest_centroid_patch_coder: PASS");
		else
			$display("tb_nearest_centroid_patch_coder: FAIL");
		$finish;
	end

endmodule
